// File: rtl/nbpsc_pkg.sv
// ----------------------------------------------------------------------------
// nbpsc_pkg
// Shared constants, types and helpers of the non-binary polar SC decoder.
// ----------------------------------------------------------------------------
package nbpsc_pkg;

    // code geometry
    localparam int CODE_LENGTH = 64;
    localparam int FIELD_SIZE  = 64;
    localparam int COST_WIDTH  = 16;

    localparam int DEPTH    = $clog2(CODE_LENGTH);
    localparam int SYM_W    = $clog2(FIELD_SIZE);
    localparam int ROWS     = 2 * CODE_LENGTH - 1;
    localparam int ROW_AW   = $clog2(ROWS);
    localparam int LVL_W    = $clog2(DEPTH + 1);
    localparam int SWP_W    = $clog2(SYM_W + 1);
    localparam int LOAD_W   = $clog2(CODE_LENGTH * FIELD_SIZE);
    localparam int VEC_W    = DEPTH - 1;

    // port field widths
    localparam int MASK_W       = 64;
    localparam int MASK_IW      = $clog2(MASK_W);
    localparam int IN_W         = 16;
    localparam int OUT_FIELD_W  = 6;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [COST_WIDTH-1:0] COST_MAX = '1;

    // controller states
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_PLAN,
        ST_F_RA,
        ST_F_RB,
        ST_F_LB,
        ST_F_RUN,
        ST_F_WR,
        ST_G_RA,
        ST_G_RB,
        ST_G_LB,
        ST_G_SW,
        ST_G_SUM,
        ST_G_MIN,
        ST_G_WR,
        ST_C_RD,
        ST_C_WR,
        ST_L_RD,
        ST_L_SCAN,
        ST_L_WR,
        ST_O_RD,
        ST_O_LD,
        ST_O_WT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic              row_rd;
        logic              row_wr;
        logic              wr_sub;
        logic [ROW_AW-1:0] row_addr;
        logic              load_we;
        logic [SYM_W-1:0]  idx;
        logic              ld_a;
        logic              ld_b;
        logic              acc_init;
        logic              f_step;
        logic              swap_en;
        logic              swap_d;
        logic [SWP_W-1:0]  swap_bit;
        logic              g_sum;
        logic              min_step;
        logic              arg_step;
        logic              ps_rd;
        logic [DEPTH-1:0]  ps_addr0;
        logic [DEPTH-1:0]  ps_addr1;
        logic              ps_wr;
        logic              ps_leaf;
        logic [DEPTH-1:0]  ps_waddr;
        logic              leaf_frozen;
        logic              dec_rd;
        logic              dec_wr;
        logic [DEPTH-1:0]  dec_addr;
        logic              out_load;
        logic              out_last;
    } t_cmd;

    // first row of the cost vectors of one tree level
    function automatic logic [ROW_AW-1:0] row_base(input logic [LVL_W-1:0] lv);
        int b;
        b = 2 * CODE_LENGTH - ((2 * CODE_LENGTH) >> lv);
        return ROW_AW'(b);
    endfunction

endpackage

// File: rtl/nbpsc_datapath.sv
// ----------------------------------------------------------------------------
// nbpsc_datapath
// Cost memory, lane-parallel add/compare unit, partial-sum and decision
// stores, and the result register.
// ----------------------------------------------------------------------------
module nbpsc_datapath import nbpsc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [IN_W-1:0]        i_cost,
    input  logic                   i_out_ready,
    output logic                   o_out_done,
    output logic                   o_out_valid,
    output logic [OUT_FIELD_W-1:0] o_out_sym,
    output logic [OUT_FIELD_W-1:0] o_out_pos,
    output logic                   o_out_last
);

    // cost vectors of every tree level, one row per vector
    logic [COST_WIDTH-1:0] r_mem [ROWS][FIELD_SIZE];
    logic [COST_WIDTH-1:0] r_row [FIELD_SIZE];
    logic [COST_WIDTH-1:0] r_a   [FIELD_SIZE];
    logic [COST_WIDTH-1:0] n_a   [FIELD_SIZE];
    logic [COST_WIDTH-1:0] r_b   [FIELD_SIZE];
    logic [COST_WIDTH-1:0] r_acc [FIELD_SIZE];
    logic [COST_WIDTH-1:0] n_acc [FIELD_SIZE];
    logic [COST_WIDTH-1:0] f_sum [FIELD_SIZE];
    logic [COST_WIDTH-1:0] wr_data [FIELD_SIZE];
    logic [COST_WIDTH-1:0] r_lo;
    logic [SYM_W-1:0]      r_best;

    // partial sums and leaf decisions
    logic [SYM_W-1:0] r_ps  [CODE_LENGTH];
    logic [SYM_W-1:0] r_dec [CODE_LENGTH];
    logic [SYM_W-1:0] r_ps0;
    logic [SYM_W-1:0] r_ps1;
    logic [SYM_W-1:0] r_dec_q;

    logic                  d_bit;
    logic                  do_swap;
    logic [COST_WIDTH-1:0] b_sel;
    logic [COST_WIDTH-1:0] scan_acc;
    logic [COST_WIDTH-1:0] scan_row;
    logic [SYM_W-1:0]      leaf_val;
    logic [SYM_W-1:0]      ps_wdata;

    logic                   r_out_valid;
    logic [OUT_FIELD_W-1:0] r_out_sym;
    logic [OUT_FIELD_W-1:0] r_out_pos;
    logic                   r_out_last;

    // saturating cost add, all-ones stands for infinite
    function automatic logic [COST_WIDTH-1:0] sat_add(input logic [COST_WIDTH-1:0] a,
                                                      input logic [COST_WIDTH-1:0] b);
        logic [COST_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_WIDTH] ? COST_MAX : s[COST_WIDTH-1:0];
    endfunction

    // lane logic: XOR permutation by single-bit swaps, add, min
    always_comb begin
        d_bit = 1'b0;
        for (int m = 0; m < SYM_W; m++) begin
            if (SWP_W'(m) == i_cmd.swap_bit) d_bit = r_ps0[m];
        end
        do_swap  = i_cmd.swap_en | (i_cmd.swap_d & d_bit);
        b_sel    = r_b[i_cmd.idx];
        scan_acc = r_acc[i_cmd.idx];
        scan_row = r_row[i_cmd.idx];
        for (int t = 0; t < FIELD_SIZE; t++) begin
            n_a[t] = r_a[t];
            if (i_cmd.ld_a) begin
                n_a[t] = r_row[t];
            end else if (do_swap) begin
                for (int m = 0; m < SYM_W; m++) begin
                    if (SWP_W'(m) == i_cmd.swap_bit) n_a[t] = r_a[SYM_W'(t ^ (1 << m))];
                end
            end
            f_sum[t] = sat_add(r_a[t], b_sel);
            n_acc[t] = r_acc[t];
            if (i_cmd.acc_init) begin
                n_acc[t] = COST_MAX;
            end else if (i_cmd.f_step) begin
                if (f_sum[t] < r_acc[t]) n_acc[t] = f_sum[t];
            end else if (i_cmd.g_sum) begin
                n_acc[t] = sat_add(r_a[t], r_b[t]);
            end
            wr_data[t] = r_acc[t] - (i_cmd.wr_sub ? r_lo : '0);
        end
        leaf_val = i_cmd.leaf_frozen ? '0 : r_best;
        ps_wdata = i_cmd.ps_leaf ? leaf_val : (r_ps0 ^ r_ps1);
    end

    // cost memory: full-row write, single-lane load write, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_wr) begin
            for (int t = 0; t < FIELD_SIZE; t++) r_mem[i_cmd.row_addr][t] <= wr_data[t];
        end
        if (i_cmd.load_we) r_mem[i_cmd.row_addr][i_cmd.idx] <= i_cost[COST_WIDTH-1:0];
        if (i_cmd.row_rd) r_row <= r_mem[i_cmd.row_addr];
    end

    // working vectors and scan registers
    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_acc <= n_acc;
        if (i_cmd.ld_b) r_b <= r_row;
        if (i_cmd.g_sum) begin
            r_lo <= COST_MAX;
        end else if (i_cmd.min_step) begin
            if (scan_acc < r_lo) r_lo <= scan_acc;
        end else if (i_cmd.arg_step) begin
            if (i_cmd.idx == '0 || scan_row < r_lo) begin
                r_lo   <= scan_row;
                r_best <= i_cmd.idx;
            end
        end
    end

    // partial-sum and decision stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.ps_rd) begin
            r_ps0 <= r_ps[i_cmd.ps_addr0];
            r_ps1 <= r_ps[i_cmd.ps_addr1];
        end
        if (i_cmd.ps_wr) r_ps[i_cmd.ps_waddr] <= ps_wdata;
        if (i_cmd.dec_wr) r_dec[i_cmd.dec_addr] <= leaf_val;
        if (i_cmd.dec_rd) r_dec_q <= r_dec[i_cmd.dec_addr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_done) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sym  <= OUT_FIELD_W'(r_dec_q);
            r_out_pos  <= OUT_FIELD_W'(i_cmd.dec_addr);
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_out_done  = r_out_valid & i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_sym   = r_out_sym;
    assign o_out_pos   = r_out_pos;
    assign o_out_last  = r_out_last;

endmodule

// File: rtl/nbpsc_ctrl.sv
// ----------------------------------------------------------------------------
// nbpsc_ctrl
// Sequencer for loading, the depth-first tree walk and result readout.
// ----------------------------------------------------------------------------
module nbpsc_ctrl import nbpsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  logic              i_out_done,
    output t_cmd              o_cmd
);

    t_state             r_state, n_state;
    logic [DEPTH-1:0]   r_s, n_s;
    logic [LVL_W-1:0]   r_lv, n_lv;
    logic [VEC_W-1:0]   r_i, n_i;
    logic [SYM_W-1:0]   r_cnt, n_cnt;
    logic [LOAD_W-1:0]  r_load, n_load;
    logic [DEPTH-1:0]   r_p, n_p;
    logic [MASK_W-1:0]  r_frozen;

    logic [DEPTH-1:0]   half;
    logic [DEPTH-1:0]   node_pos;
    logic [DEPTH-1:0]   first;
    logic [DEPTH-1:0]   mask;
    logic [DEPTH-1:0]   tz;
    logic [LVL_W-1:0]   gl;
    logic [SWP_W-1:0]   ones;
    logic               vec_last;
    logic [ROW_AW-1:0]  row_a;
    logic [ROW_AW-1:0]  row_b;
    logic [ROW_AW-1:0]  row_w;

    // frozen mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frozen <= '0;
        end else if (i_cfg_we) begin
            r_frozen <= i_cfg_wdata;
        end
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_s     <= '0;
            r_lv    <= '0;
            r_i     <= '0;
            r_cnt   <= '0;
            r_load  <= '0;
            r_p     <= '0;
        end else begin
            r_state <= n_state;
            r_s     <= n_s;
            r_lv    <= n_lv;
            r_i     <= n_i;
            r_cnt   <= n_cnt;
            r_load  <= n_load;
            r_p     <= n_p;
        end
    end

    // addressing of the current node and vector
    always_comb begin
        half     = DEPTH'(CODE_LENGTH >> (int'(r_lv) + 1));
        node_pos = (r_state == ST_C_RD || r_state == ST_C_WR) ? r_s - DEPTH'(1) : r_s;
        mask     = DEPTH'((1 << (DEPTH - int'(r_lv))) - 1);
        first    = node_pos & ~mask;
        vec_last = (DEPTH'(r_i) == half - DEPTH'(1));
        row_a    = row_base(r_lv) + ROW_AW'(r_i);
        row_b    = row_a + ROW_AW'(half);
        row_w    = row_base(LVL_W'(r_lv + 1'b1)) + ROW_AW'(r_i);
        // level of the g step that precedes the current leaf
        tz = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (r_s[k]) tz = DEPTH'(k);
        end
        gl = LVL_W'(DEPTH - 1) - LVL_W'(tz);
        // bit that the Gray-code sweep flips after this step
        ones = SWP_W'(SYM_W);
        for (int k = SYM_W - 1; k >= 0; k--) begin
            if (!r_cnt[k]) ones = SWP_W'(k);
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_s     = r_s;
        n_lv    = r_lv;
        n_i     = r_i;
        n_cnt   = r_cnt;
        n_load  = r_load;
        n_p     = r_p;
        o_in_ready = 1'b0;
        o_cmd = '0;

        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.row_addr = ROW_AW'(r_load >> SYM_W);
                o_cmd.idx      = r_load[SYM_W-1:0];
                if (i_in_valid) begin
                    o_cmd.load_we = 1'b1;
                    n_load = r_load + 1'b1;
                    if (i_in_last) begin
                        n_load  = '0;
                        n_s     = '0;
                        n_state = ST_PLAN;
                    end
                end
            end
            ST_PLAN: begin
                n_i = '0;
                if (r_s == '0) begin
                    n_lv    = '0;
                    n_state = ST_F_RA;
                end else begin
                    n_lv    = LVL_W'(DEPTH - 1);
                    n_state = (gl == LVL_W'(DEPTH - 1)) ? ST_G_RA : ST_C_RD;
                end
            end
            // f: min-sum convolution of two vectors
            ST_F_RA: begin
                o_cmd.row_rd   = 1'b1;
                o_cmd.row_addr = row_a;
                n_state = ST_F_RB;
            end
            ST_F_RB: begin
                o_cmd.ld_a     = 1'b1;
                o_cmd.row_rd   = 1'b1;
                o_cmd.row_addr = row_b;
                n_state = ST_F_LB;
            end
            ST_F_LB: begin
                o_cmd.ld_b     = 1'b1;
                o_cmd.acc_init = 1'b1;
                n_cnt   = '0;
                n_state = ST_F_RUN;
            end
            ST_F_RUN: begin
                o_cmd.f_step   = 1'b1;
                o_cmd.idx      = r_cnt ^ (r_cnt >> 1);
                o_cmd.swap_en  = (r_cnt != SYM_W'(FIELD_SIZE - 1));
                o_cmd.swap_bit = ones;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SYM_W'(FIELD_SIZE - 1)) n_state = ST_F_WR;
            end
            ST_F_WR, ST_G_WR: begin
                o_cmd.row_wr   = 1'b1;
                o_cmd.row_addr = row_w;
                o_cmd.wr_sub   = (r_state == ST_G_WR);
                if (!vec_last) begin
                    n_i     = r_i + 1'b1;
                    n_state = (r_state == ST_G_WR) ? ST_G_RA : ST_F_RA;
                end else if (r_lv == LVL_W'(DEPTH - 1)) begin
                    n_state = ST_L_RD;
                end else begin
                    n_i     = '0;
                    n_lv    = r_lv + 1'b1;
                    n_state = ST_F_RA;
                end
            end
            // g: add with the left decision applied, then normalise
            ST_G_RA: begin
                o_cmd.row_rd   = 1'b1;
                o_cmd.row_addr = row_a;
                o_cmd.ps_rd    = 1'b1;
                o_cmd.ps_addr0 = first + DEPTH'(r_i);
                o_cmd.ps_addr1 = first + DEPTH'(r_i);
                n_state = ST_G_RB;
            end
            ST_G_RB: begin
                o_cmd.ld_a     = 1'b1;
                o_cmd.row_rd   = 1'b1;
                o_cmd.row_addr = row_b;
                n_state = ST_G_LB;
            end
            ST_G_LB: begin
                o_cmd.ld_b = 1'b1;
                n_cnt   = '0;
                n_state = ST_G_SW;
            end
            ST_G_SW: begin
                o_cmd.swap_d   = 1'b1;
                o_cmd.swap_bit = SWP_W'(r_cnt);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SYM_W'(SYM_W - 1)) n_state = ST_G_SUM;
            end
            ST_G_SUM: begin
                o_cmd.g_sum = 1'b1;
                n_cnt   = '0;
                n_state = ST_G_MIN;
            end
            ST_G_MIN: begin
                o_cmd.min_step = 1'b1;
                o_cmd.idx      = r_cnt;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SYM_W'(FIELD_SIZE - 1)) n_state = ST_G_WR;
            end
            // partial-sum combine of a finished node
            ST_C_RD: begin
                o_cmd.ps_rd    = 1'b1;
                o_cmd.ps_addr0 = first + DEPTH'(r_i);
                o_cmd.ps_addr1 = first + half + DEPTH'(r_i);
                n_state = ST_C_WR;
            end
            ST_C_WR: begin
                o_cmd.ps_wr    = 1'b1;
                o_cmd.ps_waddr = first + DEPTH'(r_i);
                if (!vec_last) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_C_RD;
                end else begin
                    n_i     = '0;
                    n_lv    = r_lv - 1'b1;
                    n_state = (r_lv - 1'b1 == gl) ? ST_G_RA : ST_C_RD;
                end
            end
            // leaf decision
            ST_L_RD: begin
                o_cmd.row_rd   = 1'b1;
                o_cmd.row_addr = row_base(LVL_W'(DEPTH));
                n_cnt   = '0;
                n_state = ST_L_SCAN;
            end
            ST_L_SCAN: begin
                o_cmd.arg_step = 1'b1;
                o_cmd.idx      = r_cnt;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SYM_W'(FIELD_SIZE - 1)) n_state = ST_L_WR;
            end
            ST_L_WR: begin
                o_cmd.ps_wr       = 1'b1;
                o_cmd.ps_leaf     = 1'b1;
                o_cmd.ps_waddr    = r_s;
                o_cmd.dec_wr      = 1'b1;
                o_cmd.dec_addr    = r_s;
                o_cmd.leaf_frozen = (int'(r_s) < MASK_W) && r_frozen[MASK_IW'(r_s)];
                if (r_s == DEPTH'(CODE_LENGTH - 1)) begin
                    n_p     = '0;
                    n_state = ST_O_RD;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = ST_PLAN;
                end
            end
            // results in position order
            ST_O_RD: begin
                o_cmd.dec_rd   = 1'b1;
                o_cmd.dec_addr = r_p;
                n_state = ST_O_LD;
            end
            ST_O_LD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.dec_addr = r_p;
                o_cmd.out_last = (r_p == DEPTH'(CODE_LENGTH - 1));
                n_state = ST_O_WT;
            end
            ST_O_WT: begin
                if (i_out_done) begin
                    if (r_p == DEPTH'(CODE_LENGTH - 1)) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_p     = r_p + 1'b1;
                        n_state = ST_O_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

// File: rtl/nonbinary_polar_sc_decoder.sv
// Successive-cancellation decoder for a length-64 polar code over GF(64).
// Costs stream in one per cycle, position-major (4096 transfers per full
// block); tlast on the final cost starts the decode, after which the block
// takes no input until all 64 decisions have been transferred in position
// order. The tree is walked with one 64-lane add/compare unit and a cost
// memory that delivers one vector per cycle: an f vector reads two rows and
// sweeps the symbols in Gray-code order, a g vector swaps, adds and takes the
// minimum, a leaf scans for the argmin, and a combine reads and writes each
// partial-sum symbol. The frozen mask must be written only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// nonbinary_polar_sc_decoder
// Top level: stream ports, configuration register, sequencer and datapath.
// ----------------------------------------------------------------------------
module nonbinary_polar_sc_decoder import nbpsc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [MASK_W-1:0]      i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_W-1:0]        s_axis_tdata,   // [15:0] cost_in
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [5:0] decided_symbol, [11:6] position
    output logic                   m_axis_tlast
);

    t_cmd                   cmd;
    logic                   out_done;
    logic [OUT_FIELD_W-1:0] out_sym;
    logic [OUT_FIELD_W-1:0] out_pos;

    // sequencer
    nbpsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_done  (out_done),
        .o_cmd       (cmd)
    );

    // datapath
    nbpsc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cost      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_done  (out_done),
        .o_out_valid (m_axis_tvalid),
        .o_out_sym   (out_sym),
        .o_out_pos   (out_pos),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 2 * OUT_FIELD_W){1'b0}}, out_pos, out_sym};

`ifndef SYNTH
    // no input is taken while a result is pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is pending");

    // the final cost of a block starts the decode
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still ready after the final cost");

    // the last result carries the final position
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tdata[11:6] == OUT_FIELD_W'(CODE_LENGTH - 1)))
        else $error("last flag on a position other than the final one");
`endif

endmodule

// File: test/nonbinary_polar_sc_decoder_tb.sv
// ----------------------------------------------------------------------------
// nonbinary_polar_sc_decoder_tb
// Self-checking bench for the GF(64) SC polar decoder. Cost blocks (one
// overlong block that fills every cost, then short blocks that partly
// overwrite the stored costs) are streamed in under several frozen masks. A
// bit-accurate model of the tree walk predicts the 64 decisions of each
// block, and every output transfer is checked against them in order.
// ----------------------------------------------------------------------------
module nonbinary_polar_sc_decoder_tb;
    import nbpsc_pkg::*;

    localparam int LOAD_TOTAL = CODE_LENGTH * FIELD_SIZE;

    typedef struct {
        logic [OUT_FIELD_W-1:0] sym;
        logic [OUT_FIELD_W-1:0] pos;
        logic                   last;
    } t_decision;

    // Decision predictor and in-order checker
    class decision_scoreboard;
        logic [COST_WIDTH-1:0]  tree_cost [0:DEPTH][0:CODE_LENGTH-1][0:FIELD_SIZE-1];
        logic [SYM_W-1:0]       psum [0:2*CODE_LENGTH-1];
        logic [MASK_W-1:0]      frozen;
        int                     load_cnt;
        int                     errors;
        t_decision              pending [$];

        function new();
            frozen   = '0;
            load_cnt = 0;
            errors   = 0;
        endfunction

        function automatic logic [COST_WIDTH-1:0] sat_add(logic [COST_WIDTH-1:0] a,
                                                          logic [COST_WIDTH-1:0] b);
            logic [COST_WIDTH:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[COST_WIDTH] ? COST_MAX : s[COST_WIDTH-1:0];
        endfunction

        function automatic void walk(int lv, int s);
            int len, first, half, i, j, k;
            logic [COST_WIDTH-1:0] v, lo;
            logic [SYM_W-1:0] t, d, best;
            len   = CODE_LENGTH >> lv;
            first = s * len;
            half  = len / 2;
            if (lv == DEPTH) begin
                // leaf: frozen gives zero, else argmin with lowest index on ties
                best = '0;
                if (!frozen[s]) begin
                    lo = tree_cost[lv][0][0];
                    for (i = 1; i < FIELD_SIZE; i++)
                        if (tree_cost[lv][0][i] < lo) begin
                            lo   = tree_cost[lv][0][i];
                            best = SYM_W'(i);
                        end
                end
                psum[s]               = best;
                psum[CODE_LENGTH + s] = best;
                return;
            end
            // f: min-sum convolution into the left child
            for (i = 0; i < half; i++) begin
                for (k = 0; k < FIELD_SIZE; k++)
                    tree_cost[lv+1][i][k] = COST_MAX;
                for (j = 0; j < FIELD_SIZE; j++)
                    for (k = 0; k < FIELD_SIZE; k++) begin
                        t = SYM_W'(j ^ k);
                        v = sat_add(tree_cost[lv][i][j], tree_cost[lv][i+half][k]);
                        if (v < tree_cost[lv+1][i][t])
                            tree_cost[lv+1][i][t] = v;
                    end
            end
            walk(lv + 1, 2 * s);
            // g: shift by the left partial sum, then normalise
            for (i = 0; i < half; i++) begin
                d  = psum[CODE_LENGTH + first + i];
                lo = COST_MAX;
                for (k = 0; k < FIELD_SIZE; k++) begin
                    t = d ^ SYM_W'(k);
                    tree_cost[lv+1][i][t] = sat_add(tree_cost[lv][i][k],
                                                    tree_cost[lv][i+half][t]);
                    if (tree_cost[lv+1][i][t] < lo)
                        lo = tree_cost[lv+1][i][t];
                end
                for (k = 0; k < FIELD_SIZE; k++)
                    tree_cost[lv+1][i][k] = tree_cost[lv+1][i][k] - lo;
            end
            walk(lv + 1, 2 * s + 1);
            // combine partial sums
            for (i = 0; i < half; i++)
                psum[CODE_LENGTH + first + i] ^= psum[CODE_LENGTH + first + half + i];
        endfunction

        function automatic void note_cost(logic [IN_W-1:0] cost, logic last);
            t_decision e;
            tree_cost[0][load_cnt / FIELD_SIZE][load_cnt % FIELD_SIZE] = cost;
            load_cnt = (load_cnt + 1) % LOAD_TOTAL;
            if (!last)
                return;
            walk(0, 0);
            load_cnt = 0;
            for (int p = 0; p < CODE_LENGTH; p++) begin
                e.sym  = psum[p];
                e.pos  = OUT_FIELD_W'(p);
                e.last = (p == CODE_LENGTH - 1);
                pending.push_back(e);
            end
        endfunction

        function automatic void check_decision(logic [OUT_TDATA_W-1:0] data, logic last);
            t_decision e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected transfer, actual tdata=%h tlast=%b",
                         $time, data, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[5:0] !== e.sym) begin
                $display("%0t: symbol at position %0d: expected %0d, actual %0d",
                         $time, e.pos, e.sym, data[5:0]);
                errors++;
            end
            if (data[11:6] !== e.pos) begin
                $display("%0t: position: expected %0d, actual %0d", $time, e.pos, data[11:6]);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: tlast at position %0d: expected %b, actual %b",
                         $time, e.pos, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [MASK_W-1:0]      i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;   // [15:0] cost_in
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [5:0] decided_symbol, [11:6] position
    logic                   m_axis_tlast;

    decision_scoreboard sb = new();

    nonbinary_polar_sc_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        #(12 * 3000000);
        $display("simulation failed");
        $finish;
    end

    // mixed costs: zero, saturating, small, near-max and full range
    function automatic logic [IN_W-1:0] rand_cost();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return IN_W'($urandom_range(0, 15));
            3:       return IN_W'($urandom_range(65000, 65535));
            default: return IN_W'($urandom);
        endcase
    endfunction

    function automatic int draw_gap();
        return $urandom_range(0, 10);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_cost(logic [IN_W-1:0] cost, logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = cost;
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_cost(cost, last);
        @(negedge i_clk);
    endtask

    task automatic write_mask(logic [MASK_W-1:0] mask);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = mask;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.frozen   = mask;
    endtask

    // wait for all decisions, then let the block settle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    // 0: ramp, 1: all max, 2: all zero, otherwise mixed random
    task automatic run_block(logic [MASK_W-1:0] mask, int count, int kind);
        logic [IN_W-1:0] c;
        write_mask(mask);
        for (int n = 0; n < count; n++) begin
            case (kind)
                0:       c = IN_W'(n * 977);
                1:       c = '1;
                2:       c = '0;
                default: c = rand_cost();
            endcase
            send_cost(c, n == count - 1);
        end
        drain();
    endtask

    // output side with random back-pressure
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_decision(m_axis_tdata, m_axis_tlast);
            @(negedge i_clk);
        end
    end

    // stimulus
    initial begin
        logic [MASK_W-1:0] m;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // overlong first block: fills every cost, then wraps over the oldest
        run_block('0, LOAD_TOTAL + 5, 3);
        // short blocks: saturated ties, all frozen, alternating freeze
        run_block('0, 20, 1);
        run_block('1, 6, 2);
        run_block({32{2'b01}}, 12, 0);
        run_block({32{2'b10}}, 3, 3);

        for (int b = 0; b < 9; b++) begin
            case ($urandom_range(0, 3))
                0:       m = '0;
                1:       m = '1;
                default: m = {$urandom, $urandom};
            endcase
            run_block(m, $urandom_range(1, 40), 3);
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
